[rtl/tree_leaf_lister_bfs_core_assert.svh]
`ifndef TREE_LEAF_LISTER_BFS_CORE_ASSERT_SVH
`define TREE_LEAF_LISTER_BFS_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TLL_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define TLL_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tll_pkg.sv]
package tll_pkg;

    localparam int TLL_MAX_NODES = 16;
    localparam int TLL_IDX_W     = 4;
    localparam int TLL_IDX_SPAN  = 16;
    localparam int TLL_RES_CAP   = 16;
    localparam int TLL_CNT_W     = 5;

    typedef struct packed {
        logic [TLL_IDX_W-1:0] node_index;
        logic [TLL_IDX_W-1:0] left_child;
        logic                 has_left;
        logic [TLL_IDX_W-1:0] right_child;
        logic                 has_right;
        logic                 last_node;
    } tll_record_t;

    typedef struct packed {
        logic [TLL_IDX_W-1:0] leaf_index;
        logic                 last_leaf;
        logic                 no_root;
    } tll_leaf_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic push_root;
        logic pop;
        logic visit;
        logic push_right;
        logic finish;
        logic emit_no_root;
    } tll_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic scan_hit;
        logic more;
    } tll_status_t;

endpackage

[rtl/tll_datapath.sv]
`include "tree_leaf_lister_bfs_core_assert.svh"

module tll_datapath
    import tll_pkg::*;
#(
    parameter int MAX_NODES = TLL_MAX_NODES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tll_record_t record,
    input  tll_cmd_t    cmd,
    output tll_status_t status,
    output logic        leaf_valid,
    output tll_leaf_t   leaf
);

    localparam int TD     = (MAX_NODES < TLL_IDX_SPAN) ? MAX_NODES : TLL_IDX_SPAN;
    localparam int TA     = (TD > 1) ? $clog2(TD) : 1;
    localparam int QA     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int QW     = $clog2(MAX_NODES + 1);
    localparam int NC_MAX = (MAX_NODES < 31) ? MAX_NODES : 31;

    logic [TLL_IDX_W-1:0] left_tbl_reg  [TD];
    logic [TLL_IDX_W-1:0] right_tbl_reg [TD];
    logic [TD-1:0]        left_vld_reg;
    logic [TD-1:0]        right_vld_reg;
    logic [TD-1:0]        mark_reg;
    logic [TD-1:0]        mark_next;
    logic [TLL_CNT_W-1:0] count_reg;
    logic [TLL_CNT_W-1:0] count_next;
    logic [TLL_CNT_W-1:0] scan_reg;
    logic [TLL_CNT_W-1:0] scan_next;
    logic [TLL_CNT_W-1:0] limit;

    logic [TLL_IDX_W-1:0] q_mem [MAX_NODES];
    logic [TLL_IDX_W-1:0] q_rdata_reg;
    logic [TLL_IDX_W-1:0] cur_reg;
    logic [QW-1:0]        head_reg;
    logic [QW-1:0]        head_next;
    logic [QW-1:0]        tail_reg;
    logic [QW-1:0]        tail_next;
    logic                 q_we;
    logic [TLL_IDX_W-1:0] q_wdata;
    logic                 q_room;

    logic [TLL_CNT_W-1:0] res_cnt_reg;
    logic [TLL_CNT_W-1:0] res_cnt_next;
    logic                 pend_vld_reg;
    logic                 pend_vld_next;
    logic [TLL_IDX_W-1:0] pend_idx_reg;
    logic [TLL_IDX_W-1:0] pend_idx_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    tll_leaf_t            out_reg;
    tll_leaf_t            out_next;

    logic                 idx_ok;
    logic                 lc_ok;
    logic                 rc_ok;
    logic [TA-1:0]        vis_a;
    logic [TA-1:0]        rgt_a;
    logic                 vis_hl;
    logic                 vis_leaf;
    logic                 rgt_hr;

    assign idx_ok = 32'(record.node_index) < 32'(MAX_NODES);
    assign lc_ok  = record.has_left  && (32'(record.left_child)  < 32'(MAX_NODES));
    assign rc_ok  = record.has_right && (32'(record.right_child) < 32'(MAX_NODES));

    always_ff @(posedge clk)
    begin
        if (cmd.load && idx_ok)
        begin
            left_tbl_reg[record.node_index[TA-1:0]]  <= record.left_child;
            right_tbl_reg[record.node_index[TA-1:0]] <= record.right_child;
            left_vld_reg[record.node_index[TA-1:0]]  <= record.has_left;
            right_vld_reg[record.node_index[TA-1:0]] <= record.has_right;
        end
    end

    always_comb
    begin
        mark_next  = mark_reg;
        count_next = count_reg;
        if (cmd.finish || cmd.emit_no_root)
        begin
            mark_next  = '0;
            count_next = '0;
        end
        else if (cmd.load)
        begin
            if (lc_ok)
            begin
                mark_next[record.left_child[TA-1:0]] = 1'b1;
            end
            if (rc_ok)
            begin
                mark_next[record.right_child[TA-1:0]] = 1'b1;
            end
            if (32'(count_reg) < NC_MAX)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.load)
        begin
            scan_next = '0;
        end
        else if (cmd.scan_step)
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    assign limit = (32'(count_reg) > TLL_IDX_SPAN) ? TLL_CNT_W'(TLL_IDX_SPAN) : count_reg;

    assign vis_a    = q_rdata_reg[TA-1:0];
    assign rgt_a    = cur_reg[TA-1:0];
    assign vis_hl   = left_vld_reg[vis_a] && (32'(left_tbl_reg[vis_a]) < 32'(MAX_NODES));
    assign vis_leaf = !left_vld_reg[vis_a] && !right_vld_reg[vis_a];
    assign rgt_hr   = right_vld_reg[rgt_a] && (32'(right_tbl_reg[rgt_a]) < 32'(MAX_NODES));
    assign q_room   = tail_reg < QW'(MAX_NODES);

    always_comb
    begin
        q_we      = 1'b0;
        q_wdata   = left_tbl_reg[vis_a];
        tail_next = tail_reg;
        head_next = head_reg;
        if (cmd.push_root)
        begin
            q_we      = 1'b1;
            q_wdata   = scan_reg[TLL_IDX_W-1:0];
            tail_next = QW'(1);
            head_next = '0;
        end
        else if (cmd.visit)
        begin
            q_we    = vis_hl && q_room;
            q_wdata = left_tbl_reg[vis_a];
        end
        else if (cmd.push_right)
        begin
            q_we    = rgt_hr && q_room;
            q_wdata = right_tbl_reg[rgt_a];
        end
        if (q_we && !cmd.push_root)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next = head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[cmd.push_root ? QA'(0) : tail_reg[QA-1:0]] <= q_wdata;
        end
        if (cmd.pop)
        begin
            q_rdata_reg <= q_mem[head_reg[QA-1:0]];
        end
        if (cmd.visit)
        begin
            cur_reg <= q_rdata_reg;
        end
    end

    assign status.scan_end = scan_reg >= limit;
    assign status.scan_hit = !mark_reg[scan_reg[TA-1:0]];
    assign status.more     = (head_reg < tail_reg) || (rgt_hr && q_room);

    always_comb
    begin
        res_cnt_next  = res_cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        out_vld_next  = 1'b0;
        out_next      = '{leaf_index: pend_idx_reg, last_leaf: 1'b0, no_root: 1'b0};
        if (cmd.push_root)
        begin
            res_cnt_next  = '0;
            pend_vld_next = 1'b0;
        end
        else if (cmd.visit && vis_leaf && (32'(res_cnt_reg) < TLL_RES_CAP))
        begin
            res_cnt_next  = res_cnt_reg + 1'b1;
            pend_vld_next = 1'b1;
            pend_idx_next = q_rdata_reg;
            out_vld_next  = pend_vld_reg;
        end
        else if (cmd.finish)
        begin
            out_vld_next       = pend_vld_reg;
            out_next.last_leaf = 1'b1;
            pend_vld_next      = 1'b0;
        end
        else if (cmd.emit_no_root)
        begin
            out_vld_next = 1'b1;
            out_next     = '{leaf_index: '0, last_leaf: 1'b1, no_root: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg     <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            res_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            mark_reg     <= mark_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            res_cnt_reg  <= res_cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        out_reg      <= out_next;
    end

    assign leaf_valid = out_vld_reg;
    assign leaf       = out_reg;

    `TLL_ASSERT_IMPLY(a_no_root_last, clk, rst_n, leaf_valid && leaf.no_root, leaf.last_leaf, "no-root result without last_leaf")
    `TLL_ASSERT_IMPLY(a_queue_bounds, clk, rst_n, 1'b1, (head_reg <= tail_reg) && (tail_reg <= QW'(MAX_NODES)), "queue pointers out of range")
    `TLL_ASSERT_IMPLY(a_res_cap, clk, rst_n, 1'b1, res_cnt_reg <= TLL_CNT_W'(TLL_RES_CAP), "result count above cap")
    `TLL_ASSERT_NEXT(a_finish_flush, clk, rst_n, cmd.finish, !pend_vld_reg && (count_reg == '0), "pending leaf kept after walk")

endmodule

[rtl/tll_ctrl.sv]
module tll_ctrl
    import tll_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        last_node,
    input  tll_status_t status,
    output tll_cmd_t    cmd,
    output logic        busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_VISIT  = 3'd3;
    localparam logic [2:0] S_RIGHT  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_node)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (status.scan_end)
                begin
                    cmd.emit_no_root = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (status.scan_hit)
                begin
                    cmd.push_root = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FETCH:
            begin
                cmd.pop    = 1'b1;
                state_next = S_VISIT;
            end
            S_VISIT:
            begin
                cmd.visit  = 1'b1;
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                cmd.push_right = 1'b1;
                state_next     = status.more ? S_FETCH : S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

[rtl/tree_leaf_lister_bfs_core.sv]
// Loading: one node record per start while idle; busy stays low between records.
// Last record: it is loaded, then a root scan over the parent marks covers up to
// min(records, 16) indices; each visited node then gets a queue read, a left push,
// a right push; a flush step follows; each leaf strobes one cycle on leaf_valid.
// Reset clears the controller, parent marks, record count and queue pointers;
// child tables and the queue memory hold garbage until written.
module tree_leaf_lister_bfs_core
    import tll_pkg::*;
#(
    parameter int MAX_NODES = TLL_MAX_NODES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  tll_record_t record,
    output logic        leaf_valid,
    output tll_leaf_t   leaf
);

    tll_cmd_t    cmd;
    tll_status_t status;

    tll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_node (record.last_node),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    tll_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .record     (record),
        .cmd        (cmd),
        .status     (status),
        .leaf_valid (leaf_valid),
        .leaf       (leaf)
    );

endmodule
